### rtl/sll_pkg.sv
`timescale 1ns / 1ps

package sll_pkg;

	// Token type, also used as the open-token mode (idle shares the end code)
	typedef enum logic [2:0] {
		KIND_END     = 3'd0,
		KIND_NEWLINE = 3'd1,
		KIND_COMMENT = 3'd2,
		KIND_STRING  = 3'd3,
		KIND_NUMBER  = 3'd4,
		KIND_WORD    = 3'd5
	} tok_type_t;

	localparam tok_type_t MODE_IDLE = KIND_END;

	localparam int LINE_NO_W = 16;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// One result beat
	typedef struct packed {
		tok_type_t              tok_type;
		logic                   event_res;
		logic [7:0]             tok_byte;
		logic [LINE_NO_W-1:0]   line_no;
		logic                   last;
	} sll_res_t;

	// Results produced by one source byte, in order
	typedef struct packed {
		logic [1:0] n;
		sll_res_t   r0;
		sll_res_t   r1;
	} sll_push_t;

endpackage

### rtl/sll_core.sv
`timescale 1ns / 1ps

module sll_core import sll_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 1023,
	parameter int LINE_BITS     = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_ch,
	input  logic       q_room,
	output sll_push_t  push
);

	localparam int TL_W = $clog2(MAX_TOKEN_LEN + 1);

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 fire;

	tok_type_t            mode_q, mode_d;
	logic                 qk_q, qk_d;
	logic [TL_W-1:0]      tl_q, tl_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [LINE_BITS-1:0] start_q, start_d;

	logic [LINE_NO_W-1:0] line16, start16;
	sll_push_t            push_c;

	// Line numbers onto the fixed-width output field
	generate
		if (LINE_BITS >= LINE_NO_W) begin : g_trunc
			assign line16  = line_q[LINE_NO_W-1:0];
			assign start16 = start_q[LINE_NO_W-1:0];
		end else begin : g_ext
			assign line16  = {{(LINE_NO_W-LINE_BITS){1'b0}}, line_q};
			assign start16 = {{(LINE_NO_W-LINE_BITS){1'b0}}, start_q};
		end
	endgenerate

	// Input register handshake
	assign fire     = valid_s1 && q_room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1 <= in_ch;
		end
	end

	// Lexing step for the registered byte
	always_comb begin
		logic      room, is_blank, is_digit, is_quote, takes;
		logic      do_add, do_close, do_idle, idle_emit;
		logic      q_match;
		sll_res_t  add_res, close_res, idle_res;

		room     = tl_q < TL_W'(MAX_TOKEN_LEN);
		is_blank = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB);
		is_digit = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
		is_quote = (ch_s1 == CH_DQUOTE) || (ch_s1 == CH_SQUOTE);
		q_match  = qk_q ? (ch_s1 == CH_SQUOTE) : (ch_s1 == CH_DQUOTE);

		mode_d  = mode_q;
		qk_d    = qk_q;
		tl_d    = tl_q;
		line_d  = line_q;
		start_d = start_q;

		do_add   = 1'b0;
		do_close = 1'b0;
		do_idle  = 1'b0;
		takes    = 1'b0;

		// What the open token does with this byte
		case (mode_q)
			KIND_STRING: begin
				if (q_match) begin
					do_close = 1'b1;
				end else if (ch_s1 == CH_NUL || !room) begin
					do_close = 1'b1;
					do_idle  = 1'b1;
				end else begin
					do_add = 1'b1;
				end
			end
			KIND_COMMENT, KIND_NUMBER, KIND_WORD: begin
				if (mode_q == KIND_COMMENT) begin
					takes = (ch_s1 != CH_LF) && (ch_s1 != CH_NUL);
				end else if (mode_q == KIND_NUMBER) begin
					takes = is_digit;
				end else begin
					takes = !is_blank && (ch_s1 != CH_LF) && (ch_s1 != CH_NUL)
						&& (ch_s1 != CH_HASH);
				end
				if (takes && room) begin
					do_add = 1'b1;
				end else begin
					do_close = 1'b1;
					do_idle  = 1'b1;
				end
			end
			default: begin
				mode_d  = MODE_IDLE;
				do_idle = 1'b1;
			end
		endcase

		add_res   = '{tok_type: mode_q, event_res: 1'b0, tok_byte: ch_s1,
			line_no: start16, last: 1'b0};
		close_res = '{tok_type: mode_q, event_res: 1'b1, tok_byte: 8'h00,
			line_no: start16, last: 1'b0};

		if (do_add) begin
			tl_d = tl_q + TL_W'(1);
		end
		if (do_close) begin
			mode_d = MODE_IDLE;
			tl_d   = '0;
		end

		// Byte seen between tokens
		idle_emit = 1'b0;
		idle_res  = '{tok_type: KIND_END, event_res: 1'b1, tok_byte: 8'h00,
			line_no: line16, last: 1'b0};
		if (do_idle) begin
			if (is_blank) begin
				idle_emit = 1'b0;
			end else if (ch_s1 == CH_NUL) begin
				idle_emit = 1'b1;
				mode_d    = MODE_IDLE;
				line_d    = LINE_BITS'(1);
				start_d   = LINE_BITS'(1);
			end else if (ch_s1 == CH_LF) begin
				idle_emit         = 1'b1;
				idle_res.tok_type = KIND_NEWLINE;
				idle_res.tok_byte = CH_LF;
				mode_d            = MODE_IDLE;
				if (line_q != {LINE_BITS{1'b1}}) begin
					line_d = line_q + LINE_BITS'(1);
				end
			end else if (is_quote) begin
				start_d = line_q;
				tl_d    = '0;
				mode_d  = KIND_STRING;
				qk_d    = (ch_s1 == CH_SQUOTE);
			end else begin
				idle_emit = 1'b1;
				start_d   = line_q;
				tl_d      = TL_W'(1);
				if (ch_s1 == CH_HASH) begin
					mode_d = KIND_COMMENT;
				end else if (is_digit) begin
					mode_d = KIND_NUMBER;
				end else begin
					mode_d = KIND_WORD;
				end
				idle_res.tok_type  = mode_d;
				idle_res.event_res = 1'b0;
				idle_res.tok_byte  = ch_s1;
			end
		end

		// Order the results and mark the final one
		push_c = '0;
		if (do_add) begin
			push_c.n  = 2'd1;
			push_c.r0 = add_res;
		end else if (do_close && idle_emit) begin
			push_c.n  = 2'd2;
			push_c.r0 = close_res;
			push_c.r1 = idle_res;
		end else if (do_close) begin
			push_c.n  = 2'd1;
			push_c.r0 = close_res;
		end else if (idle_emit) begin
			push_c.n  = 2'd1;
			push_c.r0 = idle_res;
		end
		push_c.r0.last = (push_c.n == 2'd1);
		push_c.r1.last = 1'b1;
		if (!fire) begin
			push_c.n = 2'd0;
		end
	end

	assign push = push_c;

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			qk_q    <= 1'b0;
			tl_q    <= '0;
			line_q  <= LINE_BITS'(1);
			start_q <= LINE_BITS'(1);
		end else if (fire) begin
			mode_q  <= mode_d;
			qk_q    <= qk_d;
			tl_q    <= tl_d;
			line_q  <= line_d;
			start_q <= start_d;
		end
	end

endmodule

### rtl/sll_outq.sv
`timescale 1ns / 1ps

module sll_outq import sll_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sll_push_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output sll_res_t  out_res
);

	sll_res_t   buf_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	// Space for the worst case of two results
	assign room      = cnt_q <= 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign out_res   = buf_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b00, pop};
		end
	end

	// Result storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			buf_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			buf_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

endmodule

### rtl/script_line_lexer.sv
`timescale 1ns / 1ps
// Path: an accepted source byte is held in the input register, then its result beats go to the result queue.
// Throughput: one source byte per cycle while the queue has room; a byte that yields two
// beats (a token terminator) is absorbed by the four-entry result queue.
// Reset: arst_n clears the lexer to idle between tokens, line count and start line 1,
// and empties the input register and result queue.
module script_line_lexer import sll_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 1023,
	parameter int LINE_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] tok_byte, [23:8] line_no
	output logic [3:0]  m_tuser,   // [2:0] tok_type, [3] event_res
	output logic        m_tlast
);

	sll_push_t push;
	logic      q_room;
	sll_res_t  res;

	sll_core #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.LINE_BITS    (LINE_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_ch   (s_tdata),
		.q_room  (q_room),
		.push    (push)
	);

	sll_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (q_room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	// Output beat packing
	assign m_tdata = {res.line_no, res.tok_byte};
	assign m_tuser = {res.event_res, res.tok_type};
	assign m_tlast = res.last;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import sll_pkg::*;

	localparam int          MAX_LEN     = 1023;
	localparam logic [15:0] LINE_TOP    = 16'hFFFF;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          HOLD_AT     = 40;
	localparam int          HOLD_CYCLES = 400;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;      // [7:0] ch
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;            // [7:0] tok_byte, [23:8] line_no
	logic [3:0]  m_tuser;            // [2:0] tok_type, [3] event_res
	logic        m_tlast;

	script_line_lexer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Source bytes waiting to be sent, and token beats still owed by the lexer
	logic [7:0] src_bytes[$];
	sll_res_t   beats_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_sent = 0;
	int n_beats = 0;
	int n_err = 0;
	int cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// Lexer state as predicted
	tok_type_t   lx_mode = MODE_IDLE;
	logic        sq_open = 1'b0;
	int          tok_len = 0;
	logic [15:0] line_cnt = 16'd1;
	logic [15:0] start_ln = 16'd1;

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	task automatic emit(input tok_type_t ty, input logic ev, input logic [7:0] b,
			input logic [15:0] ln);
		sll_res_t r;
		r.tok_type  = ty;
		r.event_res = ev;
		r.tok_byte  = b;
		r.line_no   = ln;
		r.last      = 1'b0;
		beats_due.push_back(r);
	endtask

	task automatic append_byte(input logic [7:0] b);
		tok_len++;
		emit(lx_mode, 1'b0, b, start_ln);
	endtask

	task automatic seal_token();
		emit(lx_mode, 1'b1, 8'h00, start_ln);
		lx_mode = MODE_IDLE;
		tok_len = 0;
	endtask

	// First byte after a token: blanks skipped, end/newline are tokens of their own
	task automatic open_from_idle(input logic [7:0] b);
		if (b == CH_NUL) begin
			emit(KIND_END, 1'b1, 8'h00, line_cnt);
			line_cnt = 16'd1;
			start_ln = 16'd1;
		end else if (b == CH_LF) begin
			emit(KIND_NEWLINE, 1'b1, CH_LF, line_cnt);
			if (line_cnt != LINE_TOP)
				line_cnt++;
		end else if (b != CH_SPACE && b != CH_TAB) begin
			start_ln = line_cnt;
			tok_len = 0;
			if (b == CH_DQUOTE || b == CH_SQUOTE) begin
				lx_mode = KIND_STRING;
				sq_open = (b == CH_SQUOTE);
			end else begin
				if (b == CH_HASH)
					lx_mode = KIND_COMMENT;
				else if (is_digit(b))
					lx_mode = KIND_NUMBER;
				else
					lx_mode = KIND_WORD;
				append_byte(b);
			end
		end
	endtask

	// Predict the beats caused by one accepted source byte
	task automatic lex_byte(input logic [7:0] b);
		int n_prior;
		logic room;
		logic takes;
		sll_res_t r;
		n_prior = beats_due.size();
		room = tok_len < MAX_LEN;
		case (lx_mode)
			KIND_STRING: begin
				if (b == (sq_open ? CH_SQUOTE : CH_DQUOTE)) begin
					seal_token();
				end else if (b == CH_NUL || !room) begin
					seal_token();
					open_from_idle(b);
				end else begin
					append_byte(b);
				end
			end
			KIND_COMMENT, KIND_NUMBER, KIND_WORD: begin
				if (lx_mode == KIND_COMMENT)
					takes = (b != CH_LF) && (b != CH_NUL);
				else if (lx_mode == KIND_NUMBER)
					takes = is_digit(b);
				else
					takes = !(b == CH_SPACE || b == CH_TAB || b == CH_LF ||
						b == CH_NUL || b == CH_HASH);
				if (takes && room) begin
					append_byte(b);
				end else begin
					seal_token();
					open_from_idle(b);
				end
			end
			default: begin
				lx_mode = MODE_IDLE;
				open_from_idle(b);
			end
		endcase
		// flag the final beat of this byte
		if (beats_due.size() > n_prior) begin
			r = beats_due.pop_back();
			r.last = 1'b1;
			beats_due.push_back(r);
		end
	endtask

	// Sender: holds a byte until taken, then offers the next or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				lex_byte(s_tdata);
				n_sent <= n_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (src_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= src_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off, so the result queue fills and input stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_sent >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver and checker
	always @(posedge clk or negedge arst_n) begin
		sll_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_beats <= n_beats + 1;
				if (beats_due.size() == 0) begin
					$display("%0t: beat with none expected: type %0d ev %0d byte %0h line %0d last %0d",
						$time, m_tuser[2:0], m_tuser[3], m_tdata[7:0], m_tdata[23:8], m_tlast);
					n_err++;
				end else begin
					want = beats_due.pop_front();
					if (m_tuser[2:0] !== want.tok_type) begin
						$display("%0t: tok_type expected %0d actual %0d", $time,
							want.tok_type, m_tuser[2:0]);
						n_err++;
					end
					if (m_tuser[3] !== want.event_res) begin
						$display("%0t: event_res expected %0d actual %0d", $time,
							want.event_res, m_tuser[3]);
						n_err++;
					end
					if (m_tdata[7:0] !== want.tok_byte) begin
						$display("%0t: tok_byte expected %0h actual %0h", $time,
							want.tok_byte, m_tdata[7:0]);
						n_err++;
					end
					if (m_tdata[23:8] !== want.line_no) begin
						$display("%0t: line_no expected %0d actual %0d", $time,
							want.line_no, m_tdata[23:8]);
						n_err++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last expected %0d actual %0d", $time,
							want.last, m_tlast);
						n_err++;
					end
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d beats still owed", $time, beats_due.size());
			$display("script_line_lexer test failed");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] v;
		do
			v = 8'($urandom_range(1, 255));
		while (v == a || v == b);
		rand_byte_except = v;
	endfunction

	function automatic logic [7:0] rand_word_byte();
		logic [7:0] v;
		do
			v = 8'($urandom_range(1, 255));
		while (v == CH_SPACE || v == CH_TAB || v == CH_LF || v == CH_HASH);
		rand_word_byte = v;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			src_bytes.push_back(s[i]);
	endtask

	// One script line of random tokens, with the odd stray byte mixed in
	task automatic push_random_line();
		int n_tok;
		int kind;
		logic [7:0] q;
		n_tok = $urandom_range(0, 4);
		for (int t = 0; t < n_tok; t++) begin
			if ($urandom_range(1))
				for (int i = 0; i < $urandom_range(1, 2); i++)
					src_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				src_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
				for (int i = 0; i < $urandom_range(0, 5); i++)
					src_bytes.push_back(rand_word_byte());
			end else if (kind <= 5) begin
				for (int i = 0; i < $urandom_range(1, 5); i++)
					src_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
			end else if (kind <= 7) begin
				q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
				src_bytes.push_back(q);
				for (int i = 0; i < $urandom_range(0, 6); i++)
					src_bytes.push_back(rand_byte_except(q, CH_NUL));
				if ($urandom_range(9) != 0)
					src_bytes.push_back(q);
			end else if (kind == 8) begin
				src_bytes.push_back(CH_HASH);
				for (int i = 0; i < $urandom_range(0, 6); i++)
					src_bytes.push_back(rand_byte_except(CH_LF, CH_NUL));
				t = n_tok;
			end else begin
				for (int i = 0; i < $urandom_range(1, 3); i++)
					src_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		src_bytes.push_back(($urandom_range(9) == 0) ? CH_NUL : CH_LF);
	endtask

	task automatic push_random_lines(input int n_bytes);
		int goal;
		goal = src_bytes.size() + n_bytes;
		while (src_bytes.size() < goal)
			push_random_line();
	endtask

	// Wait until everything sent has been taken and every owed beat has come
	task automatic drain();
		while (src_bytes.size() != 0 || s_tvalid || beats_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: blanks, every token kind, terminators, both quotes, end inside tokens
		push_text(" \t");
		src_bytes.push_back(8'hFF);
		push_text("#x\n9a \"\n'\"''");
		push_text("'q");
		src_bytes.push_back(CH_NUL);
		push_text("7");
		src_bytes.push_back(CH_NUL);
		src_bytes.push_back(CH_NUL);
		src_bytes.push_back(8'h01);
		push_text("#");
		src_bytes.push_back(CH_NUL);

		// Tokens at and beyond the length cap
		src_bytes.push_back("w");
		for (int i = 0; i < 1030; i++)
			src_bytes.push_back(rand_word_byte());
		src_bytes.push_back(CH_SPACE);
		src_bytes.push_back(CH_DQUOTE);
		for (int i = 0; i < MAX_LEN; i++)
			src_bytes.push_back(rand_byte_except(CH_DQUOTE, CH_NUL));
		src_bytes.push_back(CH_DQUOTE);
		src_bytes.push_back(CH_SQUOTE);
		for (int i = 0; i < MAX_LEN + 2; i++)
			src_bytes.push_back(rand_byte_except(CH_SQUOTE, CH_NUL));
		src_bytes.push_back(CH_NUL);
		src_bytes.push_back("1");
		for (int i = 0; i < 1030; i++)
			src_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
		src_bytes.push_back(CH_LF);
		src_bytes.push_back(CH_HASH);
		for (int i = 0; i < 1030; i++)
			src_bytes.push_back(rand_byte_except(CH_LF, CH_NUL));
		src_bytes.push_back(CH_LF);
		src_bytes.push_back(CH_NUL);

		// Enough newlines to saturate the line count
		for (int i = 0; i < 65540; i++)
			src_bytes.push_back(CH_LF);
		push_text("z 5\n");
		src_bytes.push_back(CH_NUL);

		push_random_lines(250);
		drain();

		send_idle_pct = 55;
		recv_stall_pct = 0;
		push_random_lines(250);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 55;
		push_random_lines(250);
		drain();

		send_idle_pct = 24;
		recv_stall_pct = 24;
		push_random_lines(250);
		drain();

		if (beats_due.size() != 0) begin
			$display("%0t: %0d beats never arrived", $time, beats_due.size());
			n_err++;
		end
		$display("Lexed %0d source bytes into %0d beats: all token kinds, capped tokens,",
			n_sent, n_beats);
		$display("line-count saturation, a long receiver hold-off and four idling mixes.");
		if (n_err == 0)
			$display("script_line_lexer test passed");
		else
			$display("script_line_lexer test failed");
		$finish;
	end

endmodule
